>>> rtl/sptc_pkg.sv
// Shared constants, types and state codes for the swept point tile collision block.
// No dependencies.
package sptc_pkg;

	localparam int MAP_COLS   = 40;
	localparam int MAP_ROWS   = 32;
	localparam int TILE_SHIFT = 5;
	localparam int FRAC_BITS  = 4;
	localparam int UNIT_SHIFT = TILE_SHIFT + FRAC_BITS;
	localparam int MAP_CELLS  = MAP_COLS * MAP_ROWS;
	localparam int ADDR_W     = $clog2(MAP_CELLS);
	localparam int COORD_W    = 16;
	localparam int DELTA_W    = COORD_W + 1;
	localparam int LEN2_W     = 2 * COORD_W + 1;
	localparam int N_W        = 8;
	localparam int N2_W       = 2 * N_W;
	localparam int CMP_W      = N2_W + 2 * UNIT_SHIFT;
	localparam int TCRD_W     = COORD_W - 1 - UNIT_SHIFT;
	localparam int DCNT_W     = $clog2(DELTA_W);
	localparam logic [7:0] SOLID_VALUE = 8'd1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_SQX, ST_SQY, ST_NCNT,
		ST_DIVX, ST_DIVY, ST_PADDR, ST_PCHK, ST_DONE
	} state_t;

	typedef struct packed {
		logic               start;
		logic [DELTA_W-1:0] dividend;
		logic [N_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DELTA_W-1:0] quot;
		logic [N_W-1:0]     rem;
	} div_rsp_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic              data;
	} map_wr_t;

endpackage

>>> rtl/sptc_if.sv
// Valid/ready channels for query/write beats and result beats.
// No dependencies.
interface sptc_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [10:0] tile_addr;
	logic [7:0]  tile_value;
	logic signed [15:0] prev_x;
	logic signed [15:0] prev_y;
	logic signed [15:0] cur_x;
	logic signed [15:0] cur_y;
	modport source(output valid, mode, tile_addr, tile_value, prev_x, prev_y,
		cur_x, cur_y, input ready);
	modport sink(input valid, mode, tile_addr, tile_value, prev_x, prev_y,
		cur_x, cur_y, output ready);
endinterface

interface sptc_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic signed [15:0] hit_x;
	logic signed [15:0] hit_y;
	modport source(output valid, hit, hit_x, hit_y, input ready);
	modport sink(input valid, hit, hit_x, hit_y, output ready);
endinterface

>>> rtl/sptc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sptc_pkg.
module sptc_div (
	input  logic             clk,
	input  logic             arst_n,
	input  sptc_pkg::div_req_t req,
	output sptc_pkg::div_rsp_t rsp
);
	import sptc_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic [DELTA_W-1:0] quot_q;
	logic [N_W-1:0]     rem_q;
	logic [N_W-1:0]     div_q;
	logic [N_W:0]       trial;

	assign trial = {rem_q, quot_q[DELTA_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DELTA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits N_W bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			div_q  <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, div_q}) begin
				rem_q  <= N_W'(trial - {1'b0, div_q});
				quot_q <= {quot_q[DELTA_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[N_W-1:0];
				quot_q <= {quot_q[DELTA_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;
endmodule

>>> rtl/sptc_map.sv
// Solid flag memory with a clearing sweep after reset and a registered read.
// Depends on sptc_pkg.
module sptc_map (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sptc_pkg::map_wr_t         wr,
	input  logic [sptc_pkg::ADDR_W-1:0] raddr,
	output logic                      rdata,
	output logic                      ready
);
	import sptc_pkg::*;

	logic              mem [MAP_CELLS];
	logic [ADDR_W-1:0] clr_q;
	logic              clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == ADDR_W'(MAP_CELLS - 1)) clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) mem[clr_q] <= 1'b0;
		else if (wr.en) mem[wr.addr] <= wr.data;
		rdata <= mem[raddr];
	end

	assign ready = !clr_busy_q;
endmodule

>>> rtl/swept_point_tile_collision.sv
// Top level: sequencer, shared squarer, divider and map for swept point queries.
// Depends on sptc_pkg, sptc_if, sptc_div, sptc_map.
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  req     | in  | mode, tile_addr, tile_value, prev_x, prev_y, cur_x, cur_y
//  rsp     | out | hit, hit_x, hit_y
//
// After reset the map is swept clear, all 1280 cells, with req.ready low.
// A tile write passes from accept straight to the result state. A query
// passes accept, two squares, segment count search, two 17 step divisions
// (skipped when n is 0), an address and a check step per point, where the
// single map read port sets the point rate, and result; n is at most 182.
// One item at a time; the result sits in an output register, so a stalled
// rsp only holds the block once the next result is ready.
module swept_point_tile_collision (
	input  logic       clk,
	input  logic       arst_n,
	sptc_in_if.sink    req,
	sptc_out_if.source rsp
);
	import sptc_pkg::*;

	state_t state_q, state_d;

	logic signed [COORD_W-1:0] px_q, py_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;
	logic [LEN2_W-1:0]         len2_q;
	logic [N_W-1:0]            n_q, i_q;
	logic [N2_W-1:0]           n2_q;
	logic signed [DELTA_W-1:0] qx_q, qy_q, qdx_q, qdy_q;
	logic [N_W-1:0]            rx_q, ry_q, rdx_q, rdy_q;
	logic                      inmap_q;
	logic [COORD_W-1:0]        ptx_q, pty_q;
	logic                      res_hit_q;
	logic [COORD_W-1:0]        res_x_q, res_y_q;
	logic                      out_valid_q, out_hit_q;
	logic [COORD_W-1:0]        out_x_q, out_y_q;

	logic                      accept, map_ready, map_rdata, n_ok, load_out;
	logic signed [DELTA_W-1:0] mul_a;
	logic signed [2*DELTA_W-1:0] sq;
	logic [CMP_W-1:0]          n2_sh;
	logic [COORD_W-1:0]        ptx, pty;
	logic [TCRD_W-1:0]         col, row;
	logic                      inmap;
	logic [ADDR_W-1:0]         raddr;
	logic [N_W:0]              rx_n, ry_n;
	div_req_t                  dreq;
	div_rsp_t                  drsp;
	map_wr_t                   mwr;

	// shared squarer for dx^2 then dy^2
	assign mul_a = (state_q == ST_SQX) ? dx_q : dy_q;
	assign sq    = mul_a * mul_a;

	// (n*T)^2 >= len2 with n^2 tracked incrementally
	assign n2_sh = {n2_q, {(2*UNIT_SHIFT){1'b0}}};
	assign n_ok  = n2_sh >= CMP_W'(len2_q);

	// current point and its tile address
	assign ptx   = px_q + qx_q[COORD_W-1:0];
	assign pty   = py_q + qy_q[COORD_W-1:0];
	assign col   = ptx[COORD_W-2:UNIT_SHIFT];
	assign row   = pty[COORD_W-2:UNIT_SHIFT];
	assign inmap = !ptx[COORD_W-1] && !pty[COORD_W-1] &&
		(32'(col) < MAP_COLS) && (32'(row) < MAP_ROWS);
	assign raddr = ADDR_W'(32'(row) * MAP_COLS + 32'(col));

	assign rx_n = {1'b0, rx_q} + {1'b0, rdx_q};
	assign ry_n = {1'b0, ry_q} + {1'b0, rdy_q};

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	assign mwr.en   = accept && !req.mode && (32'(req.tile_addr) < MAP_CELLS);
	assign mwr.addr = req.tile_addr[ADDR_W-1:0];
	assign mwr.data = (req.tile_value == SOLID_VALUE);

	sptc_map u_map (
		.clk(clk), .arst_n(arst_n), .wr(mwr), .raddr(raddr),
		.rdata(map_rdata), .ready(map_ready)
	);

	sptc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// floor quotient and remainder from magnitude division
	function automatic logic [DELTA_W+N_W-1:0] floor_fix(input logic neg,
		input logic [DELTA_W-1:0] q, input logic [N_W-1:0] r, input logic [N_W-1:0] n);
		logic [DELTA_W-1:0] qo;
		logic [N_W-1:0]     ro;
		qo = q;
		ro = r;
		if (neg) begin
			if (r != '0) begin
				qo = ~q;
				ro = n - r;
			end else begin
				qo = -q;
			end
		end
		return {qo, ro};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		dreq.start    = 1'b0;
		dreq.dividend = dy_q[DELTA_W-1] ? -dy_q : dy_q;
		dreq.divisor  = n_q;
		case (state_q)
			ST_CLEAR: if (map_ready) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) state_d = req.mode ? ST_SQX : ST_DONE;
			end
			ST_SQX: state_d = ST_SQY;
			ST_SQY: state_d = ST_NCNT;
			ST_NCNT: begin
				if (n_ok) begin
					if (n_q == '0) begin
						state_d = ST_PADDR;
					end else begin
						state_d       = ST_DIVX;
						dreq.start    = 1'b1;
						dreq.dividend = dx_q[DELTA_W-1] ? -dx_q : dx_q;
					end
				end
			end
			ST_DIVX: begin
				if (drsp.done) begin
					state_d    = ST_DIVY;
					dreq.start = 1'b1;
				end
			end
			ST_DIVY: if (drsp.done) state_d = ST_PADDR;
			ST_PADDR: state_d = ST_PCHK;
			ST_PCHK: begin
				if ((inmap_q && map_rdata) || (i_q == n_q)) state_d = ST_DONE;
				else state_d = ST_PADDR;
			end
			ST_DONE: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q      <= req.prev_x;
				py_q      <= req.prev_y;
				dx_q      <= DELTA_W'(req.cur_x) - DELTA_W'(req.prev_x);
				dy_q      <= DELTA_W'(req.cur_y) - DELTA_W'(req.prev_y);
				n_q       <= '0;
				n2_q      <= '0;
				i_q       <= '0;
				qx_q      <= '0;
				qy_q      <= '0;
				rx_q      <= '0;
				ry_q      <= '0;
				qdx_q     <= '0;
				qdy_q     <= '0;
				rdx_q     <= '0;
				rdy_q     <= '0;
				res_hit_q <= 1'b0;
				res_x_q   <= '0;
				res_y_q   <= '0;
			end
			ST_SQX: len2_q <= sq[LEN2_W-1:0];
			ST_SQY: len2_q <= len2_q + sq[LEN2_W-1:0];
			ST_NCNT: begin
				if (!n_ok) begin
					n2_q <= n2_q + {{(N_W-1){1'b0}}, n_q, 1'b1};
					n_q  <= n_q + 1'b1;
				end
			end
			ST_DIVX: begin
				if (drsp.done) {qdx_q, rdx_q} <= floor_fix(dx_q[DELTA_W-1], drsp.quot,
					drsp.rem, n_q);
			end
			ST_DIVY: begin
				if (drsp.done) {qdy_q, rdy_q} <= floor_fix(dy_q[DELTA_W-1], drsp.quot,
					drsp.rem, n_q);
			end
			ST_PADDR: begin
				ptx_q   <= ptx;
				pty_q   <= pty;
				inmap_q <= inmap;
			end
			ST_PCHK: begin
				if (inmap_q && map_rdata) begin
					res_hit_q <= 1'b1;
					res_x_q   <= ptx_q;
					res_y_q   <= pty_q;
				end else begin
					// step floor(d*i/n) to i+1
					i_q <= i_q + 1'b1;
					if (rx_n >= {1'b0, n_q}) begin
						rx_q <= N_W'(rx_n - {1'b0, n_q});
						qx_q <= qx_q + qdx_q + 1'b1;
					end else begin
						rx_q <= rx_n[N_W-1:0];
						qx_q <= qx_q + qdx_q;
					end
					if (ry_n >= {1'b0, n_q}) begin
						ry_q <= N_W'(ry_n - {1'b0, n_q});
						qy_q <= qy_q + qdy_q + 1'b1;
					end else begin
						ry_q <= ry_n[N_W-1:0];
						qy_q <= qy_q + qdy_q;
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_hit_q <= res_hit_q;
			out_x_q   <= res_x_q;
			out_y_q   <= res_y_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.hit   = out_hit_q;
	assign rsp.hit_x = out_x_q;
	assign rsp.hit_y = out_y_q;
endmodule

>>> rtl/sptc_chk.sv
// Port-level checks for swept_point_tile_collision, attached by bind.
// Depends on the top level's ports only.
module sptc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_hit,
	input logic [15:0] rsp_hit_x,
	input logic [15:0] rsp_hit_y
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_hit_x) &&
		$stable(rsp_hit_y))
		else $error("result payload changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_hit_x == 16'd0 && rsp_hit_y == 16'd0)
		else $error("miss result with nonzero point");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("new beat taken while busy");
endmodule

bind swept_point_tile_collision sptc_chk u_sptc_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_hit(rsp.hit), .rsp_hit_x(rsp.hit_x), .rsp_hit_y(rsp.hit_y)
);
